// ===== hw/rtl/cscp_pkg.sv =====
// Package for the call stack cycle profiler.
// Sizes, event and status codes, controller state and command types.
package cscp_pkg;

    localparam int TableEntries = 64;
    localparam int StackDepth   = 32;
    localparam int SlotW        = $clog2(TableEntries);
    localparam int LevelW       = $clog2(StackDepth + 1);
    localparam int FrameW       = $clog2(StackDepth);
    localparam int FillW        = $clog2(TableEntries + 1);

    typedef enum logic [1:0] {
        K_CALL   = 2'd0,
        K_RETURN = 2'd1,
        K_READ   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_IGNORED    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_WIPE,
        S_CUR_RD,
        S_CUR_WR,
        S_WALK_RD,
        S_WALK_WR,
        S_SEARCH,
        S_ALLOC,
        S_CALL_WR,
        S_RET_RD,
        S_RET_WR,
        S_READ_RD,
        S_READ_OUT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic latch_in;
        logic cur_rd;
        logic cur_wr;
        logic walk_start;
        logic walk_rd;
        logic walk_wr;
        logic srch_start;
        logic srch_step;
        logic alloc;
        logic call_wr;
        logic ret_rd;
        logic ret_wr;
        logic read_rd;
        logic read_out;
        logic set_status;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  addr_ok;
        logic  stack_empty;
        logic  stack_full;
        logic  table_full;
        logic  clr_done;
        logic  walk_done;
        logic  srch_done;
        logic  srch_hit;
    } t_stat;

endpackage

// ===== hw/rtl/cscp_ctrl.sv =====
// Controller state machine of the call stack cycle profiler.
// Depends on cscp_pkg; drives datapath commands from its status.
module cscp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  cscp_pkg::t_stat i_stat,
    output cscp_pkg::t_cmd  o_cmd
);
    import cscp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_WIPE: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_OUT;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_CUR_RD;
                end
            end
            S_CUR_RD: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status = ST_OK;
                if (i_stat.kind == K_CLEAR) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_WIPE;
                end else if ((i_stat.kind == K_CALL && !i_stat.addr_ok) ||
                             (i_stat.kind == K_RETURN && i_stat.stack_empty)) begin
                    o_cmd.status = ST_IGNORED;
                    n_state = S_OUT;
                end else begin
                    o_cmd.cur_rd = 1'b1;
                    n_state = S_CUR_WR;
                end
            end
            S_CUR_WR: begin
                o_cmd.cur_wr = 1'b1;
                o_cmd.walk_start = 1'b1;
                n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (i_stat.walk_done) begin
                    unique case (i_stat.kind)
                        K_CALL: begin
                            o_cmd.srch_start = 1'b1;
                            n_state = S_SEARCH;
                        end
                        K_RETURN: n_state = S_RET_RD;
                        default:  n_state = S_READ_RD;
                    endcase
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                o_cmd.walk_wr = 1'b1;
                n_state = S_WALK_RD;
            end
            S_SEARCH: begin
                if (i_stat.srch_done) begin
                    o_cmd.set_status = 1'b1;
                    if (i_stat.stack_full) begin
                        o_cmd.status = ST_STACK_FULL;
                        n_state = S_OUT;
                    end else if (!i_stat.srch_hit && i_stat.table_full) begin
                        o_cmd.status = ST_TABLE_FULL;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.status = ST_OK;
                        if (i_stat.srch_hit) begin
                            o_cmd.call_wr = 1'b1;
                            n_state = S_CALL_WR;
                        end else begin
                            o_cmd.alloc = 1'b1;
                            n_state = S_ALLOC;
                        end
                    end
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_ALLOC: begin
                o_cmd.call_wr = 1'b1;
                n_state = S_CALL_WR;
            end
            S_CALL_WR: n_state = S_OUT;
            S_RET_RD: begin
                o_cmd.ret_rd = 1'b1;
                n_state = S_RET_WR;
            end
            S_RET_WR: begin
                o_cmd.ret_wr = 1'b1;
                n_state = S_OUT;
            end
            S_READ_RD: begin
                o_cmd.read_rd = 1'b1;
                n_state = S_READ_OUT;
            end
            S_READ_OUT: begin
                o_cmd.read_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_WR) |=> (r_state == S_WALK_RD))
        else $error("walk sequence broken");

endmodule

// ===== hw/rtl/cscp_dp.sv =====
// Datapath of the call stack cycle profiler: entry table, frame stack,
// charge walk, key search and result register. Depends on cscp_pkg.
module cscp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cscp_pkg::t_cmd  i_cmd,
    output cscp_pkg::t_stat o_stat,
    input  logic [1:0]      i_kind,
    input  logic [63:0]     i_timestamp,
    input  logic            i_address_valid,
    input  logic [23:0]     i_target_address,
    input  logic [7:0]      i_address_space,
    input  logic            i_interrupt_frame,
    input  logic [5:0]      i_slot,
    output logic [1:0]      o_status,
    output logic            o_slot_valid,
    output logic            o_is_reset_entry,
    output logic [23:0]     o_entry_address,
    output logic [7:0]      o_entry_space,
    output logic [31:0]     o_call_count,
    output logic [63:0]     o_inclusive_cycles,
    output logic [63:0]     o_exclusive_cycles,
    output logic [63:0]     o_min_cycles,
    output logic [63:0]     o_max_cycles
);
    import cscp_pkg::*;

    typedef struct packed {
        logic [31:0] calls;
        logic [63:0] incl;
        logic [63:0] excl;
        logic [63:0] mn;
        logic [63:0] mx;
    } t_stats;

    localparam t_stats StatsReset = '{calls: '0, incl: '0, excl: '0,
                                      mn: '1, mx: '0};

    t_stats      m_stats [TableEntries];
    logic [31:0] m_key   [TableEntries];
    logic [SlotW-1:0] m_fcaller [StackDepth];
    logic        m_firq  [StackDepth];
    logic [63:0] m_fsaved [StackDepth];

    logic [1:0]       r_kind;
    logic [63:0]      r_ts;
    logic             r_addr_ok;
    logic [31:0]      r_keyin;
    logic             r_irq;
    logic [SlotW-1:0] r_slot;

    logic [LevelW-1:0] r_level;
    logic [SlotW-1:0]  r_cur;
    logic [63:0]       r_running;
    logic [63:0]       r_last;
    logic [FillW-1:0]  r_filled;
    logic [63:0]       r_gap;

    logic [SlotW:0]    r_clr;
    logic [LevelW-1:0] r_walk;
    logic              r_walk_done;
    logic [SlotW-1:0]  r_wslot;
    logic [FillW-1:0]  r_srch;
    logic              r_hit;
    logic [SlotW-1:0]  r_found;

    t_stats           r_rd;
    logic [31:0]      r_rdkey;
    logic [SlotW-1:0] r_fcaller;
    logic [63:0]      r_fsaved;
    logic             r_firq;
    logic [31:0]      r_skey;
    logic             r_call_inc;

    logic             r_clr_busy;
    logic [1:0]       r_status;
    logic             r_slot_valid;
    logic             r_is_reset;
    logic [31:0]      r_okey;
    t_stats           r_out;

    logic [FrameW-1:0] w_top;
    logic [FrameW-1:0] w_wf;
    assign w_top = FrameW'(r_level - 1'b1);
    assign w_wf  = FrameW'(r_walk - 1'b1);

    always_comb begin
        o_stat.kind        = t_kind'(r_kind);
        o_stat.addr_ok     = r_addr_ok;
        o_stat.stack_empty = (r_level == '0);
        o_stat.stack_full  = (r_level >= LevelW'(StackDepth));
        o_stat.table_full  = (r_filled >= FillW'(TableEntries));
        o_stat.clr_done    = !r_clr_busy;
        o_stat.walk_done   = r_walk_done;
        o_stat.srch_done   = r_hit || (r_srch >= r_filled);
        o_stat.srch_hit    = r_hit;
    end

    // stats memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && r_clr_busy) begin
            m_stats[r_clr[SlotW-1:0]] <= StatsReset;
            if (r_clr[SlotW-1:0] == '0) begin
                m_key[0] <= '1;
            end
        end
        if (i_cmd.cur_rd) begin
            r_rd <= m_stats[r_cur];
        end
        if (i_cmd.cur_wr) begin
            m_stats[r_cur].excl <= r_rd.excl + r_gap;
            m_stats[r_cur].incl <= r_rd.incl + r_gap;
        end
        if (i_cmd.walk_rd) begin
            r_rd    <= m_stats[m_fcaller[w_wf]];
            r_wslot <= m_fcaller[w_wf];
            r_firq  <= m_firq[w_wf];
        end
        if (i_cmd.walk_wr) begin
            m_stats[r_wslot].incl <= r_rd.incl + r_gap;
        end
        // srch_step compares the key fetched last step; fetch next address
        if (i_cmd.srch_start) begin
            r_skey <= m_key[1];
        end
        if (i_cmd.srch_step) begin
            r_skey <= m_key[SlotW'(r_srch + 1'b1)];
        end
        if (i_cmd.alloc) begin
            m_key[r_filled[SlotW-1:0]]   <= r_keyin;
            m_stats[r_filled[SlotW-1:0]] <= StatsReset;
        end
        if (i_cmd.call_wr) begin
            r_rd <= m_stats[r_found];
        end
        if (r_call_inc && r_rd.calls != '1) begin
            m_stats[r_found].calls <= r_rd.calls + 32'd1;
        end
        if (i_cmd.ret_rd) begin
            r_rd      <= m_stats[r_cur];
            r_fcaller <= m_fcaller[w_top];
            r_fsaved  <= m_fsaved[w_top];
        end
        if (i_cmd.ret_wr) begin
            if (r_running < r_rd.mn) m_stats[r_cur].mn <= r_running;
            if (r_running > r_rd.mx) m_stats[r_cur].mx <= r_running;
        end
        if (i_cmd.read_rd) begin
            r_rd    <= m_stats[r_slot];
            r_rdkey <= m_key[r_slot];
        end
    end

    // count write in the cycle after the call_wr read
    always_ff @(posedge i_clk) begin
        r_call_inc <= i_cmd.call_wr;
        if (i_cmd.call_wr) begin
            m_fcaller[FrameW'(r_level)] <= r_cur;
            m_firq[FrameW'(r_level)]    <= r_irq;
            m_fsaved[FrameW'(r_level)]  <= r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind    <= i_kind;
            r_ts      <= i_timestamp;
            r_addr_ok <= i_address_valid;
            r_keyin   <= {i_address_space, i_target_address};
            r_irq     <= i_interrupt_frame;
            r_slot    <= i_slot;
            r_gap     <= i_timestamp - r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_cur       <= '0;
            r_running   <= '0;
            r_last      <= '0;
            r_filled    <= FillW'(1);
            r_clr       <= '0;
            r_clr_busy  <= 1'b1;
            r_walk      <= '0;
            r_walk_done <= 1'b0;
            r_srch      <= '0;
            r_hit       <= 1'b0;
            r_found     <= '0;
            r_status    <= ST_OK;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr      <= '0;
                r_clr_busy <= 1'b1;
                r_level    <= '0;
                r_cur      <= '0;
                r_running  <= '0;
                r_last     <= r_ts;
                r_filled   <= FillW'(1);
            end else if (i_cmd.clr_step && r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (SlotW+1)'(TableEntries - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.cur_wr) begin
                r_running <= r_running + r_gap;
                r_last    <= r_ts;
            end
            if (i_cmd.walk_start) begin
                r_walk      <= r_level;
                r_walk_done <= (r_level == '0);
            end
            if (i_cmd.walk_wr) begin
                r_walk      <= r_walk - 1'b1;
                r_walk_done <= r_firq || (r_walk == LevelW'(1));
            end
            if (i_cmd.srch_start) begin
                r_srch <= FillW'(1);
                r_hit  <= 1'b0;
            end
            if (i_cmd.srch_step) begin
                if (r_skey == r_keyin && r_srch < r_filled) begin
                    r_hit   <= 1'b1;
                    r_found <= r_srch[SlotW-1:0];
                end else begin
                    r_srch <= r_srch + 1'b1;
                end
            end
            if (i_cmd.alloc) begin
                r_found  <= r_filled[SlotW-1:0];
                r_filled <= r_filled + 1'b1;
            end
            if (i_cmd.call_wr) begin
                r_level   <= r_level + 1'b1;
                r_cur     <= r_found;
                r_running <= '0;
            end
            if (i_cmd.ret_wr) begin
                r_level   <= r_level - 1'b1;
                r_cur     <= r_fcaller;
                r_running <= r_running + r_fsaved;
            end
        end
    end

    logic w_fill_ok;
    assign w_fill_ok = (FillW'(r_slot) < r_filled);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_slot_valid <= 1'b0;
            r_is_reset   <= 1'b0;
            r_okey       <= '0;
            r_out        <= '0;
        end
        if (i_cmd.read_out && w_fill_ok) begin
            r_slot_valid <= 1'b1;
            r_is_reset   <= (r_slot == '0);
            r_okey       <= r_rdkey;
            r_out        <= r_rd;
        end
    end

    assign o_status           = r_status;
    assign o_slot_valid       = r_slot_valid;
    assign o_is_reset_entry   = r_is_reset;
    assign o_entry_address    = r_okey[23:0];
    assign o_entry_space      = r_okey[31:24];
    assign o_call_count       = r_out.calls;
    assign o_inclusive_cycles = r_out.incl;
    assign o_exclusive_cycles = r_out.excl;
    assign o_min_cycles       = r_out.mn;
    assign o_max_cycles       = r_out.mx;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LevelW'(StackDepth))
        else $error("stack level overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filled >= FillW'(1)) && (r_filled <= FillW'(TableEntries)))
        else $error("fill count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.call_wr |=> (r_running == '0))
        else $error("running cycles not restarted on call");

endmodule

// ===== hw/rtl/call_stack_cycle_profiler.sv =====
// Call stack cycle profiler. Accepts one event on the input channel,
// returns one result on the output channel for every event.
//
// Input events (kind): call, return, read slot, clear. Each carries the
// CPU cycle counter; the gap since the last charged event is added to the
// current function and to callers on the stack up to the first interrupt
// frame. Calls look up the 64-entry table, one key compared per cycle.
//
// Charging updates the current function first, then walks the stack
// frames one at a time, reading and then writing each; a call then
// searches the table slot by slot. A clear sweeps all 64 table entries.
// One event is taken at a time; o_stall stays high until the result
// transfer completes.
//
// Reset (synchronous, i_rst_n low) starts a sweep that resets the
// table; i_stall is honored from reset on, and o_valid holds the result
// unchanged while the receiver stalls.
module call_stack_cycle_profiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_timestamp,
    input  logic        i_address_valid,
    input  logic [23:0] i_target_address,
    input  logic [7:0]  i_address_space,
    input  logic        i_interrupt_frame,
    input  logic [5:0]  i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_slot_valid,
    output logic        o_is_reset_entry,
    output logic [23:0] o_entry_address,
    output logic [7:0]  o_entry_space,
    output logic [31:0] o_call_count,
    output logic [63:0] o_inclusive_cycles,
    output logic [63:0] o_exclusive_cycles,
    output logic [63:0] o_min_cycles,
    output logic [63:0] o_max_cycles
);
    import cscp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cscp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cscp_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_kind             (i_kind),
        .i_timestamp        (i_timestamp),
        .i_address_valid    (i_address_valid),
        .i_target_address   (i_target_address),
        .i_address_space    (i_address_space),
        .i_interrupt_frame  (i_interrupt_frame),
        .i_slot             (i_slot),
        .o_status           (o_status),
        .o_slot_valid       (o_slot_valid),
        .o_is_reset_entry   (o_is_reset_entry),
        .o_entry_address    (o_entry_address),
        .o_entry_space      (o_entry_space),
        .o_call_count       (o_call_count),
        .o_inclusive_cycles (o_inclusive_cycles),
        .o_exclusive_cycles (o_exclusive_cycles),
        .o_min_cycles       (o_min_cycles),
        .o_max_cycles       (o_max_cycles)
    );

endmodule

// ===== test/tb.sv =====
// Testbench for call_stack_cycle_profiler: random and directed profiling events.
// Depends on cscp_pkg; keeps its own profile table and call stack to predict results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cscp_pkg::*;

    typedef struct {
        t_status     status;
        logic        slot_valid;
        logic        is_reset_entry;
        logic [23:0] address;
        logic [7:0]  space;
        logic [31:0] calls;
        logic [63:0] incl;
        logic [63:0] excl;
        logic [63:0] min_c;
        logic [63:0] max_c;
    } t_report;

    class profile_board;
        bit          used [TableEntries];
        logic [31:0] key [TableEntries];
        logic [31:0] calls [TableEntries];
        logic [63:0] incl [TableEntries];
        logic [63:0] excl [TableEntries];
        logic [63:0] min_c [TableEntries];
        logic [63:0] max_c [TableEntries];
        int          caller [StackDepth];
        bit          irq_frame [StackDepth];
        logic [63:0] saved [StackDepth];
        int          depth;
        int          cur;
        logic [63:0] running;
        logic [63:0] last_ts;
        int          filled;
        t_report     pending [$];
        int          errors;
        int          reads_valid;
        int          drops;

        function void wipe(logic [63:0] now);
            for (int i = 0; i < TableEntries; i++) begin
                used[i] = 0;
                key[i] = '0;
                calls[i] = '0;
                incl[i] = '0;
                excl[i] = '0;
                min_c[i] = '1;
                max_c[i] = '0;
            end
            used[0] = 1;
            key[0] = '1;
            depth = 0;
            cur = 0;
            running = '0;
            last_ts = now;
            filled = 1;
        endfunction

        function void charge(logic [63:0] now);
            logic [63:0] gap;
            gap = now - last_ts;
            excl[cur] += gap;
            incl[cur] += gap;
            for (int i = depth - 1; i >= 0; i--) begin
                incl[caller[i]] += gap;
                if (irq_frame[i]) break;
            end
            running += gap;
            last_ts = now;
        endfunction

        function void note_event(t_kind kind, logic [63:0] ts, logic av, logic [23:0] addr,
                                 logic [7:0] sp, logic irq, logic [5:0] slot);
            t_report r;
            logic [31:0] k;
            int found;
            r = '{ST_OK, 0, 0, '0, '0, '0, '0, '0, '0, '0};
            case (kind)
                K_CALL: begin
                    if (!av) begin
                        r.status = ST_IGNORED;
                    end else begin
                        k = {sp, addr};
                        found = -1;
                        charge(ts);
                        for (int i = 1; i < filled; i++)
                            if (used[i] && key[i] == k) begin
                                found = i;
                                break;
                            end
                        if (depth >= StackDepth) begin
                            r.status = ST_STACK_FULL;
                            drops++;
                        end else if (found < 0 && filled >= TableEntries) begin
                            r.status = ST_TABLE_FULL;
                            drops++;
                        end else begin
                            if (found < 0) begin
                                found = filled++;
                                used[found] = 1;
                                key[found] = k;
                                calls[found] = '0;
                                incl[found] = '0;
                                excl[found] = '0;
                                min_c[found] = '1;
                                max_c[found] = '0;
                            end
                            caller[depth] = cur;
                            irq_frame[depth] = irq;
                            saved[depth] = running;
                            depth++;
                            if (calls[found] != '1) calls[found]++;
                            cur = found;
                            running = '0;
                        end
                    end
                end
                K_RETURN: begin
                    if (depth == 0) begin
                        r.status = ST_IGNORED;
                    end else begin
                        charge(ts);
                        if (running < min_c[cur]) min_c[cur] = running;
                        if (running > max_c[cur]) max_c[cur] = running;
                        depth--;
                        cur = caller[depth];
                        running += saved[depth];
                    end
                end
                K_READ: begin
                    charge(ts);
                    if (slot < filled && used[slot]) begin
                        reads_valid++;
                        r.slot_valid = 1;
                        r.is_reset_entry = (slot == 0);
                        r.address = key[slot][23:0];
                        r.space = key[slot][31:24];
                        r.calls = calls[slot];
                        r.incl = incl[slot];
                        r.excl = excl[slot];
                        r.min_c = min_c[slot];
                        r.max_c = max_c[slot];
                    end
                end
                default: wipe(ts);
            endcase
            pending = {pending, r};
        endfunction

        function void check_result(t_report a);
            t_report e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transfer, status %0d", $time, a.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.slot_valid !== e.slot_valid || a.is_reset_entry !== e.is_reset_entry) begin
                $display("%0t: flags exp %b%b got %b%b", $time, e.slot_valid,
                         e.is_reset_entry, a.slot_valid, a.is_reset_entry);
                errors++;
            end
            if (a.address !== e.address || a.space !== e.space) begin
                $display("%0t: key exp %h:%h got %h:%h", $time, e.space, e.address,
                         a.space, a.address);
                errors++;
            end
            if (a.calls !== e.calls) begin
                $display("%0t: calls exp %h got %h", $time, e.calls, a.calls);
                errors++;
            end
            if (a.incl !== e.incl) begin
                $display("%0t: inclusive exp %h got %h", $time, e.incl, a.incl);
                errors++;
            end
            if (a.excl !== e.excl) begin
                $display("%0t: exclusive exp %h got %h", $time, e.excl, a.excl);
                errors++;
            end
            if (a.min_c !== e.min_c) begin
                $display("%0t: min exp %h got %h", $time, e.min_c, a.min_c);
                errors++;
            end
            if (a.max_c !== e.max_c) begin
                $display("%0t: max exp %h got %h", $time, e.max_c, a.max_c);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [63:0] i_timestamp;
    logic        i_address_valid;
    logic [23:0] i_target_address;
    logic [7:0]  i_address_space;
    logic        i_interrupt_frame;
    logic [5:0]  i_slot;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_slot_valid;
    logic        o_is_reset_entry;
    logic [23:0] o_entry_address;
    logic [7:0]  o_entry_space;
    logic [31:0] o_call_count;
    logic [63:0] o_inclusive_cycles;
    logic [63:0] o_exclusive_cycles;
    logic [63:0] o_min_cycles;
    logic [63:0] o_max_cycles;

    call_stack_cycle_profiler DUT (.*);

    profile_board board;
    logic [63:0]  clock_now;
    logic [23:0]  hot_addr [8];
    logic [7:0]   hot_space [8];
    int           idle_cycles;
    int           events_sent;
    int           stall_left;
    bit           done;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_event(t_kind kind, logic [63:0] ts, logic av, logic [23:0] addr,
                              logic [7:0] sp, logic irq, logic [5:0] slot);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_timestamp <= ts;
        i_address_valid <= av;
        i_target_address <= addr;
        i_address_space <= sp;
        i_interrupt_frame <= irq;
        i_slot <= slot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_event(kind, ts, av, addr, sp, irq, slot);
        events_sent++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] step_clock();
        int p;
        p = $urandom_range(0, 99);
        if (p < 85) clock_now += $urandom_range(0, 100000);
        else if (p < 95) clock_now += {$urandom, $urandom};
        return clock_now;
    endfunction

    task automatic call_hot(logic irq);
        int h;
        h = $urandom_range(0, 7);
        send_event(K_CALL, step_clock(), 1, hot_addr[h], hot_space[h], irq, '0);
    endtask

    task automatic read_any();
        send_event(K_READ, step_clock(), 1, '0, '0, 0,
                   6'($urandom_range(0, board.filled + 2 > 63 ? 63 : board.filled + 2)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_left = 0;
        end else begin
            if (stall_left > 0) begin
                i_stall <= 1;
                stall_left--;
            end else if ($urandom_range(0, 99) < 30) begin
                stall_left = gap_len();
                i_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end else begin
                i_stall <= 0;
            end
            if (o_valid && !i_stall)
                board.check_result('{t_status'(o_status), o_slot_valid, o_is_reset_entry,
                    o_entry_address, o_entry_space, o_call_count, o_inclusive_cycles,
                    o_exclusive_cycles, o_min_cycles, o_max_cycles});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        board = new();
        board.wipe('0);
        i_rst_n = 0;
        i_valid = 0;
        i_kind = K_CALL;
        i_timestamp = '0;
        i_address_valid = 0;
        i_target_address = '0;
        i_address_space = '0;
        i_interrupt_frame = 0;
        i_slot = '0;
        clock_now = '0;
        events_sent = 0;
        for (int i = 0; i < 8; i++) begin
            hot_addr[i] = 24'($urandom);
            hot_space[i] = 8'($urandom);
        end
        hot_addr[0] = '1;
        hot_space[0] = '1;
        hot_addr[1] = '0;
        hot_space[1] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        send_event(K_READ, 64'd0, 0, '0, '0, 0, 6'd0);
        send_event(K_RETURN, 64'd5, 0, '0, '0, 0, '0);
        send_event(K_CALL, 64'd9, 0, 24'h123456, 8'h12, 0, '0);
        send_event(K_CALL, 64'd10, 1, '1, '1, 0, '0);
        send_event(K_CALL, 64'd30, 1, '0, '0, 1, '0);
        send_event(K_CALL, 64'd70, 1, '1, '1, 0, '0);
        send_event(K_READ, 64'd100, 1, '0, '0, 0, 6'd1);
        send_event(K_RETURN, 64'd150, 0, '0, '0, 0, '0);
        send_event(K_RETURN, 64'd200, 0, '0, '0, 0, '0);
        send_event(K_READ, 64'd210, 0, '0, '0, 0, 6'd0);
        send_event(K_READ, '1, 0, '0, '0, 0, 6'd2);
        send_event(K_READ, 64'd3, 0, '0, '0, 0, 6'd1);
        send_event(K_READ, 64'd4, 0, '0, '0, 0, 6'd63);
        send_event(K_CLEAR, 64'd1000, 0, '0, '0, 0, '0);
        send_event(K_READ, 64'd1500, 0, '0, '0, 0, 6'd1);
        send_event(K_READ, 64'd1600, 0, '0, '0, 0, 6'd0);
        clock_now = 64'd1600;
        for (int i = 0; i < 33; i++) call_hot(i == 5);
        read_any();
        drain();
        repeat (200) @(posedge i_clk);
        for (int i = 0; i < 70; i++)
            send_event(K_CALL, step_clock(), 1, 24'(i * 977), 8'($urandom),
                       1'($urandom), '0);
        for (int i = 0; i < 40; i++) send_event(K_RETURN, step_clock(), 1, '0, '0, 0, '0);
        for (int i = 0; i < 64; i++) send_event(K_READ, step_clock(), 1, '0, '0, 0, 6'(i));
        send_event(K_CLEAR, step_clock(), 1, '0, '0, 0, '0);

        while (events_sent < 950) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 38) call_hot(1'($urandom_range(0, 5) == 0));
            else if (p < 44) send_event(K_CALL, step_clock(), 1'($urandom_range(0, 3) != 0),
                                        24'($urandom), 8'($urandom), 1'($urandom), '0);
            else if (p < 76) send_event(K_RETURN, step_clock(), 1'($urandom),
                                        24'($urandom), 8'($urandom), 1'($urandom), '0);
            else if (p < 98) read_any();
            else send_event(K_CLEAR, step_clock(), 1'($urandom), 24'($urandom),
                            8'($urandom), 1'($urandom), 6'($urandom));
            if (events_sent % 300 == 0) drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d events: %0d valid slot reads, %0d dropped calls.",
                 events_sent, board.reads_valid, board.drops);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/cscp_pkg.sv
hw/rtl/cscp_ctrl.sv
hw/rtl/cscp_dp.sv
hw/rtl/call_stack_cycle_profiler.sv
test/tb.sv
